FILE: hdl/spad_pkg.sv
// Shared types, constants and the sech^2 lookup table for the saddle action block.
`timescale 1ns / 1ps
`default_nettype none
package spad_pkg;

    localparam int SECH_TABLE_DEPTH = 1024;
    localparam int MAX_LEVEL        = 15;
    localparam int TAB_AW           = $clog2(SECH_TABLE_DEPTH);
    // u is Q30 and the table spans [0, 8): index bits sit just under bit 33
    localparam int IDX_LSB          = 33 - TAB_AW;
    localparam int LEV_W            = 5;

    localparam logic [61:0] INNER_CAP = {62{1'b1}};

    // Table step h = 8/DEPTH in Q30
    localparam logic [63:0] H_Q30 = (64'd8 << 30) / SECH_TABLE_DEPTH;

    // Configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP      = 3'd0;
    localparam logic [2:0] CFG_INVERSE_LENGTH = 3'd1;
    localparam logic [2:0] CFG_BARRIER_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_CONF_FREQ      = 3'd3;
    localparam logic [2:0] CFG_PARTICLE_MASS  = 3'd4;

    // Control from the sequencer to the shared multiplier
    typedef struct packed {
        logic en;
        logic chunk_hi;
    } t_mul_ctl;

    typedef logic [16:0] t_sech_tab [0:SECH_TABLE_DEPTH];

    // Truncating unsigned quotient by restoring shift and subtract
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Build sech^2 samples in Q16 from the tanh addition recurrence in Q30
    function automatic t_sech_tab build_sech_tab();
        t_sech_tab   tab;
        logic [63:0] one;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h5;
        logic [63:0] h7;
        logic [63:0] th;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] num;
        logic [63:0] den;
        one = 64'd1 << 30;
        h   = H_Q30;
        h2  = (h * h) >> 30;
        h3  = (h2 * h) >> 30;
        h5  = (h3 * h2) >> 30;
        h7  = (h5 * h2) >> 30;
        th  = h - udiv64(h3, 64'd3) + udiv64(64'd2 * h5, 64'd15)
              - udiv64(64'd17 * h7, 64'd315);
        t   = 64'd0;
        for (int k = 0; k <= SECH_TABLE_DEPTH; k++) begin
            t2     = (t * t) >> 30;
            tab[k] = (t2 >= one) ? 17'd0 : 17'((one - t2) >> 14);
            num    = (t + th) << 30;
            den    = one + ((t * th) >> 30);
            t      = udiv64(num, den);
            if (t > one) begin
                t = one;
            end
        end
        return tab;
    endfunction

    localparam t_sech_tab SECH_TAB = build_sech_tab();

endpackage
`default_nettype wire

FILE: hdl/spad_mul.sv
// Shared signed 36x36 multiplier with a chunked product accumulator.
`timescale 1ns / 1ps
`default_nettype none
module spad_mul (
    input  wire logic                  i_clk,
    input  wire spad_pkg::t_mul_ctl    i_ctl,
    input  wire logic signed [35:0]    i_a,
    input  wire logic signed [35:0]    i_b,
    output logic signed [99:0]         o_acc
);

    logic signed [71:0] w_prod;
    logic signed [99:0] w_ext;
    logic signed [99:0] n_acc;
    logic signed [99:0] r_acc;

    // Multiply, then start a new sum or add the upper chunk at 32-bit weight
    always_comb begin
        w_prod = i_a * i_b;
        w_ext  = 100'(w_prod);
        n_acc  = i_ctl.chunk_hi ? (r_acc + (w_ext <<< 32)) : w_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

FILE: hdl/saddle_potential_action_difference_top.sv
// Top level: saddle potential action difference accumulator with its sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Each input transfer carries a new and an old bead position and a level; the block
// evaluates the saddle potential at both positions, scales the difference by tau*2^level
// and adds it into a saturating 48-bit sum. A transfer with tlast set produces one output
// transfer holding the sum (tdata) and the saturation flag (tuser), then the sum clears.
// The block takes no new item until it is through with the last one: tready is high only
// in the idle state; a single 36x36 multiplier is stepped through 20 multiplications by
// the sequencer, 15 steps per potential plus 5 for the difference and the sum. The output
// register lets the next item be accepted while a result waits; a second result waits
// for the first to be taken, which stretches the final step by the output stall.
module saddle_potential_action_difference_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // new_x[23:0], new_y[47:24], old_x[71:48], old_y[95:72], level[99:96], zero pad
    input  wire logic [103:0] i_s_axis_tdata,
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // action_difference[47:0]
    output logic [47:0]       o_m_axis_tdata,
    // overflow[0]
    output logic              o_m_axis_tuser,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_wr_data
);

    typedef enum logic [20:0] {
        ST_IDLE = 21'h000001,
        ST_U    = 21'h000002,
        ST_TA   = 21'h000004,
        ST_TB   = 21'h000008,
        ST_S    = 21'h000010,
        ST_SV   = 21'h000020,
        ST_VX   = 21'h000040,
        ST_W    = 21'h000080,
        ST_W2   = 21'h000100,
        ST_Y2   = 21'h000200,
        ST_M0   = 21'h000400,
        ST_M1   = 21'h000800,
        ST_TS   = 21'h001000,
        ST_T0   = 21'h002000,
        ST_T1   = 21'h004000,
        ST_V    = 21'h008000,
        ST_DV   = 21'h010000,
        ST_D0   = 21'h020000,
        ST_D1   = 21'h040000,
        ST_DS   = 21'h080000,
        ST_ACC  = 21'h100000
    } t_state;

    localparam int IDX_LSB = spad_pkg::IDX_LSB;
    localparam int TAB_AW  = spad_pkg::TAB_AW;
    localparam int LEV_W   = spad_pkg::LEV_W;

    // Clamp an unsigned shifted product to the inner cap
    function automatic logic [61:0] sat62(input logic [99:0] v);
        return (|v[99:62]) ? spad_pkg::INNER_CAP : v[61:0];
    endfunction

    t_state r_state;

    logic [23:0]        r_tau;
    logic [23:0]        r_inv_len;
    logic signed [31:0] r_v0;
    logic [31:0]        r_omega;
    logic [31:0]        r_mass;

    logic signed [23:0] r_new_x;
    logic signed [23:0] r_new_y;
    logic signed [23:0] r_old_x;
    logic signed [23:0] r_old_y;
    logic [3:0]         r_level;
    logic               r_last;
    logic               r_phase;

    logic                r_szero;
    logic [TAB_AW-1:0]   r_idx;
    logic [15:0]         r_f;
    logic [16:0]         r_ta;
    logic [16:0]         r_tb;
    logic signed [17:0]  r_s;
    logic signed [32:0]  r_vx;
    logic [33:0]         r_aw;
    logic [50:0]         r_w2;
    logic [34:0]         r_y2;
    logic [61:0]         r_t1;
    logic signed [63:0]  r_pn;
    logic signed [63:0]  r_po;
    logic                r_dneg;
    logic [63:0]         r_adv;
    logic [61:0]         r_mag;
    logic signed [47:0]  r_sum;
    logic                r_flag;

    logic               r_out_valid;
    logic [47:0]        r_out_data;
    logic               r_out_user;

    spad_pkg::t_mul_ctl w_ctl;
    logic signed [35:0] w_ma;
    logic signed [35:0] w_mb;
    logic signed [99:0] w_acc;
    logic [99:0]        w_acc_u;

    logic signed [23:0] w_x;
    logic signed [23:0] w_y;
    logic [23:0]        w_ax;
    logic [23:0]        w_ay;
    logic signed [17:0] w_tdiff;
    logic signed [17:0] w_s;
    logic signed [32:0] w_vx;
    logic signed [33:0] w_w;
    logic [61:0]        w_t2;
    logic signed [63:0] w_v;
    logic signed [64:0] w_dv;
    logic [61:0]        w_mag;
    logic [LEV_W-1:0]   w_lev;
    logic signed [47:0] w_c;
    logic               w_c_sat;
    logic signed [48:0] w_sum;
    logic signed [47:0] w_sum_sat;
    logic               w_sum_ovf;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign w_acc_u         = $unsigned(w_acc);

    spad_mul u_mul (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_acc (w_acc)
    );

    // Datapath terms around the shared multiplier
    always_comb begin
        w_x       = r_phase ? r_old_x : r_new_x;
        w_y       = r_phase ? r_old_y : r_new_y;
        w_ax      = w_x[23] ? 24'(-w_x) : 24'(w_x);
        w_ay      = w_y[23] ? 24'(-w_y) : 24'(w_y);
        w_tdiff   = $signed({1'b0, r_tb}) - $signed({1'b0, r_ta});
        w_s       = r_szero ? 18'sd0 : ($signed({1'b0, r_ta}) + 18'(w_acc >>> 16));
        w_vx      = w_acc[48:16];
        w_w       = $signed({2'b00, r_omega}) + 34'(w_vx);
        w_t2      = sat62(w_acc_u >> 17);
        w_v       = 64'(r_vx >>> 1) + $signed({2'b00, w_t2});
        w_dv      = 65'(r_pn) - 65'(r_po);
        w_mag     = sat62(w_acc_u >> 16);
        w_lev     = ({1'b0, r_level} > LEV_W'(spad_pkg::MAX_LEVEL)) ?
                    LEV_W'(spad_pkg::MAX_LEVEL) : {1'b0, r_level};
        w_c_sat   = 1'b0;
        if (r_dneg) begin
            if (r_mag > 62'(48'h8000_0000_0000)) begin
                w_c     = {1'b1, 47'd0};
                w_c_sat = 1'b1;
            end else begin
                w_c = -$signed(48'(r_mag));
            end
        end else begin
            if (r_mag > 62'(48'h7FFF_FFFF_FFFF)) begin
                w_c     = {1'b0, {47{1'b1}}};
                w_c_sat = 1'b1;
            end else begin
                w_c = $signed(48'(r_mag));
            end
        end
        w_sum     = 49'(r_sum) + 49'(w_c);
        w_sum_ovf = (w_sum[48] != w_sum[47]);
        w_sum_sat = w_sum_ovf ? (w_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                              : w_sum[47:0];
    end

    // Select multiplier operands for each step
    always_comb begin
        w_ctl = '0;
        w_ma  = '0;
        w_mb  = '0;
        unique case (r_state)
            ST_U: begin
                w_ctl.en = 1'b1;
                w_ma     = {12'd0, w_ax};
                w_mb     = {12'd0, r_inv_len};
            end
            ST_S: begin
                w_ctl.en = 1'b1;
                w_ma     = 36'(w_tdiff);
                w_mb     = {20'd0, r_f};
            end
            ST_VX: begin
                w_ctl.en = 1'b1;
                w_ma     = 36'(r_v0);
                w_mb     = 36'(r_s);
            end
            ST_W2: begin
                w_ctl.en = 1'b1;
                w_ma     = {2'd0, r_aw};
                w_mb     = {2'd0, r_aw};
            end
            ST_Y2: begin
                w_ctl.en = 1'b1;
                w_ma     = {12'd0, w_ay};
                w_mb     = {12'd0, w_ay};
            end
            ST_M0: begin
                w_ctl.en = 1'b1;
                w_ma     = {4'd0, r_mass};
                w_mb     = {4'd0, r_w2[31:0]};
            end
            ST_M1: begin
                w_ctl.en       = 1'b1;
                w_ctl.chunk_hi = 1'b1;
                w_ma           = {4'd0, r_mass};
                w_mb           = {17'd0, r_w2[50:32]};
            end
            ST_T0: begin
                w_ctl.en = 1'b1;
                w_ma     = {4'd0, r_t1[31:0]};
                w_mb     = {1'b0, r_y2};
            end
            ST_T1: begin
                w_ctl.en       = 1'b1;
                w_ctl.chunk_hi = 1'b1;
                w_ma           = {6'd0, r_t1[61:32]};
                w_mb           = {1'b0, r_y2};
            end
            ST_D0: begin
                w_ctl.en = 1'b1;
                w_ma     = {4'd0, r_adv[31:0]};
                w_mb     = {12'd0, r_tau};
            end
            ST_D1: begin
                w_ctl.en       = 1'b1;
                w_ctl.chunk_hi = 1'b1;
                w_ma           = {4'd0, r_adv[63:32]};
                w_mb           = {12'd0, r_tau};
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau     <= 24'd65536;
            r_inv_len <= 24'd65536;
            r_v0      <= 32'sd65536;
            r_omega   <= 32'd65536;
            r_mass    <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                spad_pkg::CFG_TIME_STEP:      r_tau     <= i_cfg_wr_data[23:0];
                spad_pkg::CFG_INVERSE_LENGTH: r_inv_len <= i_cfg_wr_data[23:0];
                spad_pkg::CFG_BARRIER_HEIGHT: r_v0      <= $signed(i_cfg_wr_data);
                spad_pkg::CFG_CONF_FREQ:      r_omega   <= i_cfg_wr_data;
                spad_pkg::CFG_PARTICLE_MASS:  r_mass    <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Step the sequencer and hold intermediate values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= 1'b0;
            r_sum       <= '0;
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the held result once taken, unless a new one replaces it now
            if (r_out_valid && i_m_axis_tready && !((r_state == ST_ACC) && r_last)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_new_x <= $signed(i_s_axis_tdata[23:0]);
                        r_new_y <= $signed(i_s_axis_tdata[47:24]);
                        r_old_x <= $signed(i_s_axis_tdata[71:48]);
                        r_old_y <= $signed(i_s_axis_tdata[95:72]);
                        r_level <= i_s_axis_tdata[99:96];
                        r_last  <= i_s_axis_tlast;
                        r_phase <= 1'b0;
                        r_state <= ST_U;
                    end
                end
                ST_U:  r_state <= ST_TA;
                ST_TA: begin
                    r_szero <= |w_acc_u[99:33];
                    r_idx   <= w_acc_u[32:IDX_LSB];
                    r_f     <= w_acc_u[IDX_LSB-1 -: 16];
                    r_ta    <= spad_pkg::SECH_TAB[w_acc_u[32:IDX_LSB]];
                    r_state <= ST_TB;
                end
                ST_TB: begin
                    r_tb    <= spad_pkg::SECH_TAB[(TAB_AW+1)'(r_idx) + 1'b1];
                    r_state <= ST_S;
                end
                ST_S:  r_state <= ST_SV;
                ST_SV: begin
                    r_s     <= w_s;
                    r_state <= ST_VX;
                end
                ST_VX: r_state <= ST_W;
                ST_W: begin
                    r_vx    <= w_vx;
                    r_aw    <= w_w[33] ? 34'(-w_w) : 34'(w_w);
                    r_state <= ST_W2;
                end
                ST_W2: r_state <= ST_Y2;
                ST_Y2: begin
                    r_w2    <= w_acc_u[66:16];
                    r_state <= ST_M0;
                end
                ST_M0: begin
                    r_y2    <= w_acc_u[46:12];
                    r_state <= ST_M1;
                end
                ST_M1: r_state <= ST_TS;
                ST_TS: begin
                    r_t1    <= sat62(w_acc_u >> 16);
                    r_state <= ST_T0;
                end
                ST_T0: r_state <= ST_T1;
                ST_T1: r_state <= ST_V;
                ST_V: begin
                    if (r_phase) begin
                        r_po    <= w_v;
                        r_state <= ST_DV;
                    end else begin
                        r_pn    <= w_v;
                        r_phase <= 1'b1;
                        r_state <= ST_U;
                    end
                end
                ST_DV: begin
                    r_dneg  <= w_dv[64];
                    r_adv   <= w_dv[64] ? 64'(-w_dv) : 64'(w_dv);
                    r_state <= ST_D0;
                end
                ST_D0: r_state <= ST_D1;
                ST_D1: r_state <= ST_DS;
                ST_DS: begin
                    r_mag   <= (w_mag > (spad_pkg::INNER_CAP >> w_lev)) ?
                               spad_pkg::INNER_CAP : (w_mag << w_lev);
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    // On the last item of a section, wait while a previous result is still unclaimed
                    if (!(r_last && r_out_valid && !i_m_axis_tready)) begin
                        if (r_last) begin
                            r_out_data  <= w_sum_sat;
                            r_out_user  <= r_flag | w_c_sat | w_sum_ovf;
                            r_out_valid <= 1'b1;
                            r_sum       <= '0;
                            r_flag      <= 1'b0;
                        end else begin
                            r_sum  <= w_sum_sat;
                            r_flag <= r_flag | w_c_sat | w_sum_ovf;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: dv/saddle_potential_action_difference_top_tb.sv
// Testbench for the saddle potential action difference accumulator.
`timescale 1ns / 1ps
`default_nettype none
module saddle_potential_action_difference_top_tb;

    localparam int         LIMIT_CYCLES = 3000000;
    localparam int         SETTLE       = 80;
    localparam int         TAB_N        = spad_pkg::SECH_TABLE_DEPTH;
    localparam logic [63:0] CAP62       = (64'd1 << 62) - 1;
    localparam longint     SUM_MAX      = 64'sh7FFF_FFFF_FFFF;
    localparam longint     SUM_MIN      = -SUM_MAX - 1;

    typedef struct {
        logic signed [23:0] nx;
        logic signed [23:0] ny;
        logic signed [23:0] ox;
        logic signed [23:0] oy;
        logic [3:0]         lev;
        logic               last;
    } t_bead_pair;

    typedef struct {
        logic [47:0] sum;
        logic        ovf;
    } t_section_total;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [103:0] s_data = '0;
    logic         s_last = 1'b0;
    logic         m_ready = 1'b0;
    logic         cfg_en = 1'b0;
    logic [2:0]   cfg_idx = spad_pkg::CFG_TIME_STEP;
    logic [31:0]  cfg_data = '0;
    wire          o_s_axis_tready;
    wire          o_m_axis_tvalid;
    wire  [47:0]  o_m_axis_tdata;
    wire          o_m_axis_tuser;

    saddle_potential_action_difference_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_index     (cfg_idx),
        .i_cfg_wr_data   (cfg_data)
    );

    // Predictor state
    logic [16:0]    sech_lut [0:TAB_N];
    logic [63:0]    tau = 64'd65536;
    logic [63:0]    inv_len = 64'd65536;
    longint         v0 = 65536;
    logic [63:0]    omega = 64'd65536;
    logic [63:0]    mass = 64'd65536;
    longint         run_sum = 0;
    logic           run_sat = 1'b0;

    t_bead_pair     pending_pairs[$];
    t_section_total section_totals[$];
    t_bead_pair     cur_pair;
    int             gap_left = 0;
    int             stall_left = 0;
    bit             calm = 1'b0;
    int             mismatches = 0;
    int             pairs_sent = 0;
    int             totals_seen = 0;
    int             sat_seen = 0;
    int             cycles = 0;

    always #5 i_clk = ~i_clk;

    // Build sech^2 samples (Q16) from the tanh addition recurrence (Q30)
    function automatic void build_sech_lut();
        logic [63:0] one;
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] h3;
        logic [63:0] h5;
        logic [63:0] h7;
        logic [63:0] th;
        logic [63:0] t;
        logic [63:0] t2;
        one = 64'd1 << 30;
        h   = (64'd8 << 30) / TAB_N;
        h2  = (h * h) >> 30;
        h3  = (h2 * h) >> 30;
        h5  = (h3 * h2) >> 30;
        h7  = (h5 * h2) >> 30;
        th  = h - h3 / 3 + (64'd2 * h5) / 15 - (64'd17 * h7) / 315;
        t   = 0;
        for (int k = 0; k <= TAB_N; k++) begin
            t2 = (t * t) >> 30;
            sech_lut[k] = (t2 >= one) ? 17'd0 : 17'((one - t2) >> 14);
            t = ((t + th) << 30) / (one + ((t * th) >> 30));
            if (t > one) t = one;
        end
    endfunction

    // Full product, shifted and capped at 2^62-1
    function automatic logic [63:0] mul_shr_cap(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p > {64'd0, CAP62}) ? CAP62 : p[63:0];
    endfunction

    function automatic logic [63:0] mag64(longint a);
        return (a < 0) ? 64'(-a) : 64'(a);
    endfunction

    function automatic longint saddle_potential(logic signed [23:0] x, logic signed [23:0] y);
        logic [63:0] u;
        logic [63:0] p;
        logic [63:0] idx;
        logic [63:0] f;
        longint      ta;
        longint      tb;
        longint      s;
        longint      vx;
        longint      w;
        logic [63:0] w2;
        logic [63:0] ay;
        logic [63:0] y2;
        logic [63:0] t;
        u = mag64(longint'(x)) * inv_len;
        if (u >= (64'd8 << 30)) begin
            s = 0;
        end else begin
            p   = u * TAB_N;
            idx = p >> 33;
            f   = (p >> 17) & 64'hFFFF;
            if (idx >= TAB_N) idx = TAB_N - 1;
            ta  = longint'(sech_lut[idx]);
            tb  = longint'(sech_lut[idx + 1]);
            s   = ta + (((tb - ta) * longint'(f)) >>> 16);
        end
        vx = (v0 * s) >>> 16;
        w  = longint'(omega) + vx;
        w2 = mul_shr_cap(mag64(w), mag64(w), 16);
        ay = mag64(longint'(y));
        y2 = (ay * ay) >> 12;
        t  = mul_shr_cap(mass, w2, 16);
        t  = mul_shr_cap(t, y2, 17);
        return (vx >>> 1) + longint'(t);
    endfunction

    // Fold one accepted bead pair into the section sum; queue a total on last
    task automatic accumulate_pair(t_bead_pair bp);
        longint      dv;
        logic [63:0] mag;
        longint      c;
        longint      sum;
        int          lv;
        dv  = saddle_potential(bp.nx, bp.ny) - saddle_potential(bp.ox, bp.oy);
        lv  = (bp.lev > spad_pkg::MAX_LEVEL) ? spad_pkg::MAX_LEVEL : int'(bp.lev);
        mag = mul_shr_cap(mag64(dv), tau, 16);
        mag = (mag > (CAP62 >> lv)) ? CAP62 : (mag << lv);
        if (dv < 0) begin
            if (mag > 64'(SUM_MAX) + 1) begin
                c = SUM_MIN;
                run_sat = 1'b1;
            end else begin
                c = -longint'(mag);
            end
        end else begin
            if (mag > 64'(SUM_MAX)) begin
                c = SUM_MAX;
                run_sat = 1'b1;
            end else begin
                c = longint'(mag);
            end
        end
        sum = run_sum + c;
        if (sum > SUM_MAX) begin
            sum = SUM_MAX;
            run_sat = 1'b1;
        end else if (sum < SUM_MIN) begin
            sum = SUM_MIN;
            run_sat = 1'b1;
        end
        run_sum = sum;
        if (bp.last) begin
            section_totals.push_back('{sum: run_sum[47:0], ovf: run_sat});
            run_sum = 0;
            run_sat = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver: hold the transfer until taken, then present the next pending pair
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || o_s_axis_tready) begin
            if (s_valid) begin
                accumulate_pair(cur_pair);
                pairs_sent++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_pairs.size() != 0) begin
                cur_pair = pending_pairs.pop_front();
                s_data   <= {4'd0, cur_pair.lev, cur_pair.oy, cur_pair.ox,
                             cur_pair.ny, cur_pair.nx};
                s_last   <= cur_pair.last;
                s_valid  <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compare each transfer with the oldest total
    always @(posedge i_clk) begin
        t_section_total exp_t;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            totals_seen++;
            if (o_m_axis_tuser) sat_seen++;
            if (section_totals.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected total %h ovf %b", o_m_axis_tdata,
                             o_m_axis_tuser);
            end else begin
                exp_t = section_totals.pop_front();
                if (o_m_axis_tdata !== exp_t.sum || o_m_axis_tuser !== exp_t.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: total exp %h/%b got %h/%b", exp_t.sum,
                                 exp_t.ovf, o_m_axis_tdata, o_m_axis_tuser);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            m_ready <= i_rst_n;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_en   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            spad_pkg::CFG_TIME_STEP:      tau = 64'(val[23:0]);
            spad_pkg::CFG_INVERSE_LENGTH: inv_len = 64'(val[23:0]);
            spad_pkg::CFG_BARRIER_HEIGHT: v0 = longint'(signed'(val));
            spad_pkg::CFG_CONF_FREQ:      omega = 64'(val);
            spad_pkg::CFG_PARTICLE_MASS:  mass = 64'(val);
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] ts, logic [31:0] il, logic [31:0] bh,
                             logic [31:0] cf, logic [31:0] pm);
        write_reg(spad_pkg::CFG_TIME_STEP, ts);
        write_reg(spad_pkg::CFG_INVERSE_LENGTH, il);
        write_reg(spad_pkg::CFG_BARRIER_HEIGHT, bh);
        write_reg(spad_pkg::CFG_CONF_FREQ, cf);
        write_reg(spad_pkg::CFG_PARTICLE_MASS, pm);
        @(posedge i_clk);
        cfg_en <= 1'b0;
    endtask

    // Let every pair be taken and every total arrive, then let the pipe settle
    task automatic drain();
        while (pending_pairs.size() != 0 || s_valid || section_totals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_pair(int nx, int ny, int ox, int oy, int lev, bit last);
        pending_pairs.push_back('{nx: nx[23:0], ny: ny[23:0], ox: ox[23:0],
                                  oy: oy[23:0], lev: lev[3:0], last: last});
    endtask

    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom;
        if (r < 8) return $urandom_range(0, 65535) - 32768;
        return $urandom_range(0, 1 << 20) - (1 << 19);
    endfunction

    task automatic add_random(int n);
        for (int k = 0; k < n; k++)
            add_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     $urandom_range(0, 15), (k == n - 1) || ($urandom_range(0, 3) == 0));
    endtask

    initial begin
        build_sech_lut();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset configuration, field extremes, equal positions, far x
        add_pair(0, 0, 0, 0, 0, 1);
        add_pair(8388607, 8388607, -8388608, -8388608, 15, 1);
        add_pair(-8388608, -8388608, 8388607, 8388607, 15, 0);
        add_pair(16384, 16384, 16384, 16384, 7, 1);
        add_pair(200000, 0, 0, 0, 0, 0);
        add_pair(0, 16384, 0, -16384, 3, 0);
        add_pair(131071, 5000, -131072, 5000, 1, 1);
        add_pair(0, 8388607, 0, 0, 15, 0);
        add_pair(0, 8388607, 0, 0, 15, 0);
        add_pair(0, 0, 0, -8388608, 15, 1);
        add_pair(12345, -54321, -8388608, 8388607, 9, 1);
        drain();

        // Extreme settings: everything at its top, then its bottom, then a mix of the two
        write_all(32'hFFFFFF, 32'hFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_pair(8388607, 8388607, 0, 0, 15, 1);
        add_pair(0, 8388607, 0, 0, 0, 0);
        add_pair(0, 0, 0, -8388608, 15, 1);
        add_random(60);
        drain();
        write_all(32'h0, 32'h0, 32'h80000000, 32'h0, 32'h0);
        add_pair(8388607, 8388607, -8388608, -8388608, 15, 1);
        add_random(40);
        drain();
        write_all(32'hFFFFFF, 32'h1, 32'h80000000, 32'h0, 32'h1);
        add_random(60);
        drain();

        // Random settings, mostly moderate, with a calm phase now and then
        for (int ph = 0; ph < 8; ph++) begin
            calm = (ph % 3 == 1);
            if (ph % 4 == 3)
                write_all($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                write_all($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 19),
                          $urandom, $urandom_range(0, 1 << 20),
                          $urandom_range(0, 1 << 18));
            add_random(95);
            drain();
        end
        calm = 1'b0;

        $display("Ran %0d bead pairs over 12 register settings, extremes included.",
                 pairs_sent);
        $display("Checked %0d section totals, %0d of them flagged saturated.",
                 totals_seen, sat_seen);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
hdl/spad_pkg.sv
hdl/spad_mul.sv
hdl/saddle_potential_action_difference_top.sv
dv/saddle_potential_action_difference_top_tb.sv
